/* rtl/swqt_pkg.sv */
// Constants and types shared by the sliding window quality trimmer.
`default_nettype none
package swqt_pkg;

  localparam int unsigned MaxLen  = 1024;
  localparam int unsigned Window  = 6;
  localparam int unsigned QualW   = 8;
  localparam int unsigned LenW    = 11;
  localparam int unsigned PosW    = $clog2(MaxLen + 1);
  localparam int unsigned SumW    = $clog2(Window * ((1 << QualW) - 1) + 1);
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 11;
  localparam int unsigned OutDatW = ((LenW + 7) / 8) * 8;
  localparam int unsigned OutUsrW = 2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegMinQuality = cfg_idx_t'(0);
  localparam cfg_idx_t RegMinLength  = cfg_idx_t'(1);

  localparam logic [PosW-1:0] PosMax    = PosW'(MaxLen);
  localparam logic [PosW-1:0] PosWindow = PosW'(Window);

endpackage
`default_nettype wire

/* rtl/sliding_window_quality_trim_top.sv */
// Sliding window quality trimmer: one quality character per transaction, one result per read.
//
// Input stream (s_axis): one quality byte per transaction in tdata, tlast on the
// final character of a read. Output stream (m_axis): one transaction per read,
// issued for the character that carries tlast, with the kept length in tdata
// and the passed / window_failed flags in tuser.
// Configuration: cfg_index_i selects min_quality (0) or min_length (1); any
// other index is ignored. Writes are always taken (cfg_ready_o is high) and
// are meant to happen only while no read is in flight.
// Throughput: one character per cycle. The window sum, the threshold compare
// and the cut decision are settled in the cycle a character is taken; the
// running state and the output register are loaded at that edge.
// The result is registered: m_axis_tvalid rises in the cycle after the tlast character is taken.
// Stall: the output register holds its result while m_axis_tready is low;
// s_axis_tready then drops, so no further character is taken until the
// result is delivered. With the output register empty or draining, input
// continues without a bubble.
// Reset: state and the output valid clear; min_quality returns to 52 and
// min_length to 50. No clearing pass is needed.
`default_nettype none
module sliding_window_quality_trim_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [swqt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [swqt_pkg::CfgDatW-1:0]      cfg_data_i,
  // character stream
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [swqt_pkg::QualW-1:0]        s_axis_tdata,  // [7:0] quality_char
  input  wire logic                              s_axis_tlast,  // last_char
  // result stream
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output      logic [swqt_pkg::OutDatW-1:0]      m_axis_tdata,  // [10:0] kept_length, rest 0
  output      logic [swqt_pkg::OutUsrW-1:0]      m_axis_tuser   // [0] passed, [1] window_failed
);

  localparam int unsigned PosW  = swqt_pkg::PosW;
  localparam int unsigned SumW  = swqt_pkg::SumW;
  localparam int unsigned QualW = swqt_pkg::QualW;
  localparam int unsigned LenW  = swqt_pkg::LenW;
  localparam int unsigned Win   = swqt_pkg::Window;

  // configuration registers
  logic [QualW-1:0] min_quality_q;
  logic [LenW-1:0]  min_length_q;

  // read state
  logic [QualW-1:0] win_q [Win];
  logic [SumW-1:0]  sum_q, sum_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             cut_q;
  logic [PosW-1:0]  cut_pt_q;

  // output register
  logic             out_valid_q;
  logic [LenW-1:0]  kept_q, kept_d;
  logic             passed_q, passed_d;
  logic             failed_q, failed_d;

  logic             in_xfer;
  logic             active;
  logic             full_win;
  logic [SumW-1:0]  sum_add;
  logic [SumW-1:0]  thresh;
  logic             cut_hit;
  logic [PosW-1:0]  cut_pt_new;
  logic [PosW-1:0]  kept_pos;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_quality_q <= QualW'(52);
      min_length_q  <= LenW'(50);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        swqt_pkg::RegMinQuality: min_quality_q <= cfg_data_i[QualW-1:0];
        swqt_pkg::RegMinLength:  min_length_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // window arithmetic for the character on the input
  always_comb begin
    active     = pos_q < swqt_pkg::PosMax;
    full_win   = pos_q >= swqt_pkg::PosWindow;
    sum_add    = sum_q + SumW'(s_axis_tdata);
    sum_d      = full_win ? (sum_add - SumW'(win_q[0])) : sum_add;
    thresh     = SumW'(SumW'(min_quality_q) * SumW'(Win));
    cut_hit    = active && full_win && !cut_q && (sum_d < thresh);
    cut_pt_new = pos_q - swqt_pkg::PosWindow;
    pos_d      = active ? (pos_q + PosW'(1)) : pos_q;

    if (cut_hit) begin
      kept_pos = cut_pt_new;
    end else if (cut_q) begin
      kept_pos = cut_pt_q;
    end else begin
      kept_pos = pos_d;
    end
    kept_d   = kept_pos[LenW-1:0];
    passed_d = kept_d >= min_length_q;
    failed_d = cut_q || cut_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      pos_q    <= '0;
      cut_q    <= 1'b0;
      cut_pt_q <= '0;
    end else if (in_xfer) begin
      if (s_axis_tlast) begin
        sum_q    <= '0;
        pos_q    <= '0;
        cut_q    <= 1'b0;
        cut_pt_q <= '0;
      end else if (active) begin
        sum_q <= sum_d;
        pos_q <= pos_d;
        if (cut_hit) begin
          cut_q    <= 1'b1;
          cut_pt_q <= cut_pt_new;
        end
      end
    end
  end

  // character history; older entries are only read once refilled by the read
  always_ff @(posedge clk_i) begin
    if (in_xfer && active) begin
      for (int k = 0; k < Win - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[Win-1] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tlast) begin
      kept_q   <= kept_d;
      passed_q <= passed_d;
      failed_q <= failed_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = swqt_pkg::OutDatW'(kept_q);
  assign m_axis_tuser  = {failed_q, passed_q};

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= swqt_pkg::PosMax)
    else $error("position ran past the maximum length");

  a_cut_after_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cut_q |-> (pos_q > swqt_pkg::PosWindow) && (cut_pt_q < pos_q))
    else $error("cut recorded before a full window was tested");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast) |=> (pos_q == '0) && !cut_q && (sum_q == '0))
    else $error("read state not cleared after the last character");

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && failed_q) |-> (kept_q < LenW'(swqt_pkg::MaxLen - Win)))
    else $error("cut point beyond the last testable window");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while a result is stalled");
`endif

endmodule
`default_nettype wire
